// ===== rtl/core/prmd_pkg.sv =====
// ----------------------------------------------------------------------------
// prmd_pkg
// Shared types and constants for the palette run-length mask decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package prmd_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);        // palette address bits
	localparam int PAL_CW = $clog2(PALETTE_ENTRIES + 1);    // entry counter bits

	// configuration register indexes
	localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

	// pixel formats
	localparam logic FMT_PALETTE_RLE = 1'b0;
	localparam logic FMT_RGB565      = 1'b1;

	// control byte fields
	localparam logic [7:0] RUN_BLACK_BIT = 8'h80;
	localparam logic [7:0] RUN_LEN_MASK  = 8'h7F;

	typedef struct packed {
		logic        pixel_format;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} cfg_t;

	// decoded result waiting for the palette read data
	typedef struct packed {
		logic       use_palette;  // color comes from the palette read
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [6:0] count;
		logic       row_end;
		logic       image_end;
	} s1_t;

endpackage

`default_nettype wire

// ===== rtl/core/prmd_palette_ram.sv =====
// ----------------------------------------------------------------------------
// prmd_palette_ram
// Palette memory: one write port, one registered read port, 24-bit RGB words.
// ----------------------------------------------------------------------------
`default_nettype none

module prmd_palette_ram (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [prmd_pkg::PAL_AW-1:0]  wr_addr,
	input  wire logic [23:0]                  wr_data,
	input  wire logic                         rd_en,
	input  wire logic [prmd_pkg::PAL_AW-1:0]  rd_addr,
	output logic      [23:0]                  rd_data
);
	import prmd_pkg::*;

	logic [23:0] mem [PALETTE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/prmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// prmd_ctrl
// Byte decoder: palette load, run/literal/RGB565 decode, row and image
// counters. Produces one registered decoded result per emitting byte.
// ----------------------------------------------------------------------------
`default_nettype none

module prmd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prmd_pkg::cfg_t    cfg,
	input  wire logic              accept,     // item taken this cycle
	input  wire logic              advance,    // stage 1 may load
	input  wire logic [7:0]        body_byte,
	input  wire logic              image_start,
	output logic                   s1_valid,
	output prmd_pkg::s1_t          s1,
	output logic [23:0]            pal_rd_data
);
	import prmd_pkg::*;

	logic [PAL_CW-1:0] entry_q;
	logic [1:0]        part_q;
	logic [7:0]        red_q, green_q;
	logic [6:0]        lit_q;
	logic [16:0]       col_q;
	logic [15:0]       row_q;
	logic [7:0]        low_q;
	logic              phase_q, done_q;

	// effective state after an image_start clear
	logic [PAL_CW-1:0] entry_e;
	logic [1:0]        part_e;
	logic [6:0]        lit_e;
	logic [16:0]       col_e;
	logic [15:0]       row_e;
	logic [7:0]        low_e;
	logic              phase_e, done_e;

	// next state
	logic [PAL_CW-1:0] entry_d;
	logic [1:0]        part_d;
	logic [6:0]        lit_d;
	logic [16:0]       col_d, col_sum;
	logic [15:0]       row_d, row_inc;
	logic [7:0]        low_d;
	logic              phase_d, done_d;

	logic              emit, may_end, pal_wr;
	logic              load_red, load_green;
	s1_t               res;
	logic [15:0]       word565;
	logic [6:0]        run_len;
	logic              idx_ok;

	assign run_len = 7'(body_byte & RUN_LEN_MASK);
	assign word565 = {body_byte, low_e};
	assign idx_ok  = {1'b0, body_byte} < 9'(PALETTE_ENTRIES);
	assign col_sum = col_e + {10'd0, res.count};
	assign row_inc = row_e + 16'd1;

	always_comb begin
		entry_e = image_start ? '0    : entry_q;
		part_e  = image_start ? 2'd0  : part_q;
		lit_e   = image_start ? 7'd0  : lit_q;
		col_e   = image_start ? 17'd0 : col_q;
		row_e   = image_start ? 16'd0 : row_q;
		low_e   = image_start ? 8'd0  : low_q;
		phase_e = image_start ? 1'b0  : phase_q;
		done_e  = image_start ? 1'b0  : done_q;
	end

	always_comb begin
		entry_d    = entry_e;
		part_d     = part_e;
		lit_d      = lit_e;
		col_d      = col_e;
		row_d      = row_e;
		low_d      = low_e;
		phase_d    = phase_e;
		done_d     = done_e;
		emit       = 1'b0;
		may_end    = 1'b0;
		pal_wr     = 1'b0;
		load_red   = 1'b0;
		load_green = 1'b0;
		res        = '0;

		if (entry_e < PAL_CW'(PALETTE_ENTRIES)) begin
			// palette load: R, G, then B commits the whole entry
			case (part_e)
				2'd0: begin
					load_red = 1'b1;
					part_d   = 2'd1;
				end
				2'd1: begin
					load_green = 1'b1;
					part_d     = 2'd2;
				end
				default: begin
					pal_wr  = 1'b1;
					part_d  = 2'd0;
					entry_d = entry_e + PAL_CW'(1);
				end
			endcase
		end else if (done_e || (row_e >= cfg.image_height)) begin
			done_d = 1'b1;
		end else if (cfg.pixel_format == FMT_RGB565) begin
			if (!phase_e) begin
				low_d   = body_byte;
				phase_d = 1'b1;
			end else begin
				phase_d   = 1'b0;
				emit      = 1'b1;
				may_end   = 1'b1;
				res.red   = {word565[15:11], 3'b000};
				res.green = {word565[10:5], 2'b00};
				res.blue  = {word565[4:0], 3'b000};
				res.count = 7'd1;
			end
		end else if (lit_e != 7'd0) begin
			lit_d           = lit_e - 7'd1;
			emit            = 1'b1;
			may_end         = (lit_e == 7'd1);
			res.use_palette = idx_ok;
			res.count       = 7'd1;
		end else if (run_len != 7'd0) begin
			if ((body_byte & RUN_BLACK_BIT) != 8'd0) begin
				emit      = 1'b1;
				may_end   = 1'b1;
				res.count = run_len;
			end else begin
				lit_d = run_len;
			end
		end

		if (emit) begin
			col_d = col_sum;
			if (may_end && (col_sum >= {1'b0, cfg.image_width})) begin
				res.row_end = 1'b1;
				col_d       = 17'd0;
				row_d       = row_inc;
				if (row_inc >= cfg.image_height) begin
					done_d        = 1'b1;
					res.image_end = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q  <= '0;
			part_q   <= 2'd0;
			lit_q    <= 7'd0;
			col_q    <= 17'd0;
			row_q    <= 16'd0;
			low_q    <= 8'd0;
			phase_q  <= 1'b0;
			done_q   <= 1'b0;
			s1_valid <= 1'b0;
		end else begin
			if (accept) begin
				entry_q <= entry_d;
				part_q  <= part_d;
				lit_q   <= lit_d;
				col_q   <= col_d;
				row_q   <= row_d;
				low_q   <= low_d;
				phase_q <= phase_d;
				done_q  <= done_d;
			end
			if (advance) begin
				s1_valid <= accept && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && load_red) begin
			red_q <= body_byte;
		end
		if (accept && load_green) begin
			green_q <= body_byte;
		end
		if (advance) begin
			s1 <= res;
		end
	end

	prmd_palette_ram u_palette (
		.clk     (clk),
		.wr_en   (accept && pal_wr),
		.wr_addr (entry_e[PAL_AW-1:0]),
		.wr_data ({red_q, green_q, body_byte}),
		.rd_en   (advance),
		.rd_addr (body_byte[PAL_AW-1:0]),
		.rd_data (pal_rd_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/palette_rle_mask_decoder.sv =====
// ----------------------------------------------------------------------------
// palette_rle_mask_decoder
// Decodes an image body byte stream into pixel runs (palette RLE or RGB565).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one body byte per item, with
//   image_start marking the first palette byte of a new image; it clears all
//   counters. The first 3*PALETTE_ENTRIES bytes load the palette (R, G, B).
//   Output channel (out_valid/out_ready) carries zero or one pixel run per
//   input byte: color, repeat_count, row_end and image_end.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   pixel_format, image_width, image_height; always ready, write when idle.
// Timing:
//   One byte per cycle sustained while the output is not stalled. Each result
//   passes through the decode stage (palette read), then the output register.
// Reset:
//   arst_n clears counters and the pipeline; registers go to RLE mode,
//   1x1 image. Palette contents are undefined until loaded.
// Stall:
//   With out_ready low, the output register and the decode stage both hold;
//   in_ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_rle_mask_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  body_byte,
	input  wire logic        image_start,
	// pixel run output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [6:0]       repeat_count,
	output logic             row_end,
	output logic             image_end,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import prmd_pkg::*;

	cfg_t        cfg_q;
	logic        s1_valid;
	s1_t         s1;
	logic [23:0] pal_rd_data;
	logic        out_slot;    // output register free or draining this cycle
	logic        accept;

	// register writes, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= FMT_PALETTE_RLE;
			cfg_q.image_width  <= 16'd1;
			cfg_q.image_height <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[0];
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode stage loads whenever it is empty or its item moves on
	assign out_slot = !out_valid || out_ready;
	assign in_ready = !s1_valid || out_slot;
	assign accept   = in_valid && in_ready;

	prmd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.advance     (in_ready),
		.body_byte   (body_byte),
		.image_start (image_start),
		.s1_valid    (s1_valid),
		.s1          (s1),
		.pal_rd_data (pal_rd_data)
	);

	// output register; literal pixels take their color from the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_slot) begin
			out_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_slot && s1_valid) begin
			red          <= s1.use_palette ? pal_rd_data[23:16] : s1.red;
			green        <= s1.use_palette ? pal_rd_data[15:8]  : s1.green;
			blue         <= s1.use_palette ? pal_rd_data[7:0]   : s1.blue;
			repeat_count <= s1.count;
			row_end      <= s1.row_end;
			image_end    <= s1.image_end;
		end
	end

	// decode stage must hold its item while the output is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && out_valid && !out_ready |=> s1_valid)
		else $error("decode stage lost an item under stall");

	// input only backs up when both stages are full
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid && out_valid)
		else $error("in_ready low with free stage");

	// an image end always closes a row
	a_img_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image_end without row_end");

	// every result stands for at least one pixel
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_count != 7'd0)
		else $error("empty pixel run emitted");

endmodule

`default_nettype wire

// ===== test/palette_rle_mask_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_rle_mask_decoder_tb
// Self-checking bench for the palette run-length / RGB565 image body decoder.
// Drives palette loads and pixel byte streams through the valid/ready input,
// models palette, row/column counters and modes per byte, and compares every
// pixel run on the output against the modeled run in order. Directed tests
// cover reset defaults, run corners, RGB565 packing, mode switches mid-image,
// zero sizes and a 17-bit column count, then random images follow.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_rle_mask_decoder_tb;

	import prmd_pkg::*;

	// index 3 decodes to no register; writes to it must be dropped
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	localparam int PAL_BYTES          = 3 * PALETTE_ENTRIES;
	localparam int SETTLE_CYCLES      = 4;      // 2-stage pipe plus margin
	localparam int DRAIN_LIMIT        = 5000;   // cycles to wait for stragglers
	localparam int RANDOM_PIXEL_BYTES = 1800;
	localparam int IMAGE_BYTE_BUDGET  = 400;    // cap per random image
	localparam int STALL_HOLD_CYCLES  = 80;

	// RGB565 words for the packing test: zero, all ones, each channel at max,
	// and an alternating pattern
	localparam logic [95:0] RGB_WORDS = {16'h0000, 16'hFFFF, 16'h001F,
		16'h07E0, 16'hF800, 16'hAA55};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [6:0] count;
		logic       row_end;
		logic       image_end;
	} pixel_run_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  body_byte;
	logic        image_start;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [6:0]  repeat_count;
	logic        row_end;
	logic        image_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// decoder state as the bench sees it
	logic [23:0] pal_mem [PALETTE_ENTRIES];
	int unsigned pal_fill;
	logic [6:0]  lits_left;
	logic [16:0] col_cnt;
	logic [15:0] row_cnt;
	logic [7:0]  low_byte;
	logic        have_low;
	logic        img_done;
	logic        fmt_reg;
	logic [15:0] width_reg;
	logic [15:0] height_reg;

	pixel_run_t  pending_runs [$];   // runs decoded but not yet seen on the output
	int          errors;
	bit          in_burst;           // sender: no gaps while set
	bit          out_burst;          // receiver: no stalls while set
	int          sink_hold;          // one-shot long receiver hold-off, in cycles

	always #6 clk = ~clk;

	palette_rle_mask_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.body_byte    (body_byte),
		.image_start  (image_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.repeat_count (repeat_count),
		.row_end      (row_end),
		.image_end    (image_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Decoder model
	// ------------------------------------------------------------------------

	// Adds the run's pixels to the row. The row closes only when the run is
	// allowed to close it (not mid literal run) and the width is reached; an
	// overshoot stays with the row and the column restarts at zero.
	task automatic push_run(input logic [7:0] r, g, b, input logic [6:0] n,
			input bit may_end);
		pixel_run_t run;
		run.red       = r;
		run.green     = g;
		run.blue      = b;
		run.count     = n;
		run.row_end   = 1'b0;
		run.image_end = 1'b0;
		col_cnt = col_cnt + 17'(n);
		if (may_end && col_cnt >= 17'(width_reg)) begin
			run.row_end = 1'b1;
			col_cnt = '0;
			row_cnt = row_cnt + 16'd1;
			if (row_cnt >= height_reg) begin
				img_done = 1'b1;
				run.image_end = 1'b1;
			end
		end
		pending_runs.push_back(run);
	endtask

	// One accepted byte: palette fill first, then pixel data in the current mode.
	task automatic decode_byte(input logic [7:0] b, input logic st);
		logic [15:0] word;
		logic [23:0] rgb;
		if (st) begin
			pal_fill  = 0;
			lits_left = '0;
			col_cnt   = '0;
			row_cnt   = '0;
			low_byte  = '0;
			have_low  = 1'b0;
			img_done  = 1'b0;
		end
		if (pal_fill < PAL_BYTES) begin
			// R, G, B per entry
			case (pal_fill % 3)
				0: pal_mem[pal_fill / 3][23:16] = b;
				1: pal_mem[pal_fill / 3][15:8]  = b;
				default: pal_mem[pal_fill / 3][7:0] = b;
			endcase
			pal_fill++;
		end else if (img_done || row_cnt >= height_reg) begin
			// finished image (or zero height): swallow until next image_start
			img_done = 1'b1;
		end else if (fmt_reg == FMT_RGB565) begin
			if (!have_low) begin
				low_byte = b;
				have_low = 1'b1;
			end else begin
				have_low = 1'b0;
				word = {b, low_byte};
				push_run({word[15:11], 3'b000}, {word[10:5], 2'b00},
					{word[4:0], 3'b000}, 7'd1, 1'b1);
			end
		end else if (lits_left != 0) begin
			rgb = (int'(b) < PALETTE_ENTRIES) ? pal_mem[b] : 24'h000000;
			lits_left = lits_left - 7'd1;
			push_run(rgb[23:16], rgb[15:8], rgb[7:0], 7'd1, lits_left == 0);
		end else if ((b & RUN_LEN_MASK) != 0) begin
			if ((b & RUN_BLACK_BIT) != 0)
				push_run(8'h00, 8'h00, 8'h00, 7'(b & RUN_LEN_MASK), 1'b1);
			else
				lits_left = 7'(b & RUN_LEN_MASK);
		end
		// zero-length control byte: nothing
	endtask

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offers one byte after a random gap; valid stays up between back-to-back
	// items so it never gets two assignments in one step.
	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		body_byte   <= b;
		image_start <= st;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, st);
	endtask

	// more = 1 keeps cfg_valid up for a following write
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val,
			input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (!more)
			cfg_valid <= 1'b0;
		case (idx)
			CFG_PIXEL_FORMAT: fmt_reg    = val[0];
			CFG_IMAGE_WIDTH:  width_reg  = val;
			CFG_IMAGE_HEIGHT: height_reg = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic f, input logic [15:0] w, h);
		write_reg(CFG_PIXEL_FORMAT, {15'b0, f}, 1'b1);
		write_reg(CFG_IMAGE_WIDTH, w, 1'b1);
		write_reg(CFG_IMAGE_HEIGHT, h, 1'b0);
	endtask

	// Input idle, all runs out, then a few cycles so bytes that made no run
	// have left the pipe too. Safe point for register writes.
	task automatic wait_drained();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (pending_runs.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// full palette, image_start on the first byte
	task automatic load_palette();
		for (int i = 0; i < PAL_BYTES; i++)
			send_byte(8'($urandom_range(0, 255)), i == 0);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: random stall before each run, plus an optional long hold-off
	// counted here so the block backs up into its input.
	// ------------------------------------------------------------------------
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				out_ready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			stall = out_burst ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------------
	// Output check: every accepted run against the oldest modeled run
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : run_check
		pixel_run_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_runs.size() == 0) begin
				$error("unexpected run: rgb %0d/%0d/%0d count %0d row_end %0d image_end %0d",
					red, green, blue, repeat_count, row_end, image_end);
				errors++;
			end else begin
				want = pending_runs.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("repeat_count", 8'(want.count), 8'(repeat_count));
				check_field("row_end", 8'(want.row_end), 8'(row_end));
				check_field("image_end", 8'(want.image_end), 8'(image_end));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// No register writes: 1x1 RLE image. Two literals overshoot the single
	// column, close the row and the image; the trailing run is dropped.
	task automatic test_reset_defaults();
		load_palette();
		send_byte(8'd2, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(RUN_BLACK_BIT | 8'd3, 1'b0);
		wait_drained();
	endtask

	// 8x3 RLE: zero-length literal and black runs, extreme indices, overshoot,
	// a max-length black run, exact fit on the last row, bytes after the end.
	task automatic test_rle_runs();
		configure(FMT_PALETTE_RLE, 16'd8, 16'd3);
		load_palette();
		send_byte(8'h00, 1'b0);
		send_byte(RUN_BLACK_BIT, 1'b0);
		send_byte(RUN_BLACK_BIT | 8'd3, 1'b0);
		send_byte(8'd2, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(RUN_BLACK_BIT | 8'd5, 1'b0);                // col 10, row 1 ends
		send_byte(RUN_BLACK_BIT | RUN_LEN_MASK, 1'b0);        // row 2 ends
		send_byte(8'd1, 1'b0);
		send_byte(8'h80, 1'b0);                               // literal index
		send_byte(RUN_BLACK_BIT | 8'd7, 1'b0);                // exact fit, image end
		send_byte(RUN_BLACK_BIT | 8'd2, 1'b0);
		send_byte(8'd5, 1'b0);
		wait_drained();
	endtask

	// 3x2 RGB565: little-endian pairs, channel extremes, left-shift expansion.
	task automatic test_rgb565();
		logic [15:0] word;
		configure(FMT_RGB565, 16'd3, 16'd2);
		load_palette();
		for (int i = 0; i < 6; i++) begin
			word = RGB_WORDS[95 - 16 * i -: 16];
			send_byte(word[7:0], 1'b0);
			send_byte(word[15:8], 1'b0);
		end
		send_byte(8'h12, 1'b0);
		wait_drained();
	endtask

	// Pending literal count and held low byte survive mode flips; then
	// image_start mid-image and again mid-palette restarts everything.
	task automatic test_mode_switch();
		configure(FMT_PALETTE_RLE, 16'd4, 16'd4);
		load_palette();
		send_byte(8'd3, 1'b0);
		send_byte(8'h10, 1'b0);
		wait_drained();
		write_reg(CFG_PIXEL_FORMAT, {15'b0, FMT_RGB565}, 1'b0);
		send_byte(8'h34, 1'b0);                               // low byte held
		wait_drained();
		write_reg(CFG_PIXEL_FORMAT, {15'b0, FMT_PALETTE_RLE}, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h21, 1'b0);                               // literal run done
		wait_drained();
		write_reg(CFG_PIXEL_FORMAT, {15'b0, FMT_RGB565}, 1'b0);
		send_byte(8'h12, 1'b0);                               // pairs with 0x34
		wait_drained();
		write_reg(CFG_PIXEL_FORMAT, {15'b0, FMT_PALETTE_RLE}, 1'b0);
		send_byte(8'd2, 1'b0);
		// restart in the middle of the image, then again mid-palette
		for (int i = 0; i < 150; i++)
			send_byte(8'($urandom_range(0, 255)), i == 0);
		load_palette();
		send_byte(RUN_BLACK_BIT | 8'd4, 1'b0);
		wait_drained();
	endtask

	// Width 0: any non-empty run closes a row. Height 0 ends the image at
	// the next byte with no run, and it stays ended even if height grows.
	// A write to the unused index must change nothing.
	task automatic test_zero_sizes();
		configure(FMT_PALETTE_RLE, 16'd0, 16'd3);
		load_palette();
		send_byte(RUN_BLACK_BIT, 1'b0);
		send_byte(RUN_BLACK_BIT | 8'd1, 1'b0);
		wait_drained();
		write_reg(CFG_UNUSED_INDEX, 16'hFFFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'd1, 1'b0);
		send_byte(8'h05, 1'b0);
		wait_drained();
		write_reg(CFG_IMAGE_HEIGHT, 16'd0, 1'b0);
		send_byte(RUN_BLACK_BIT | 8'd2, 1'b0);
		wait_drained();
		write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF, 1'b0);
		send_byte(RUN_BLACK_BIT | 8'd2, 1'b0);
		wait_drained();
	endtask

	// One 65535-wide row of max black runs: the column count passes 16 bits
	// before the row closes. The receiver holds off while the sender streams
	// at full rate, then the sender pauses until all runs are out.
	task automatic test_long_row_stall();
		configure(FMT_PALETTE_RLE, 16'hFFFF, 16'd1);
		load_palette();
		in_burst  = 1'b1;
		sink_hold = STALL_HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_byte(RUN_BLACK_BIT | RUN_LEN_MASK, 1'b0);
		wait_drained();
		out_burst = 1'b1;
		while (!img_done)
			send_byte(RUN_BLACK_BIT | RUN_LEN_MASK, 1'b0);
		in_burst  = 1'b0;
		out_burst = 1'b0;
		wait_drained();
	endtask

	// Random images: random mode and sizes (extremes now and then), some
	// aborted palette loads, mostly well-formed runs with noise bytes,
	// occasional mode flips mid-image and bursts on either side.
	task automatic test_random_images();
		int         pix_bytes;
		int         img_bytes;
		int         k;
		logic       f;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0] b;
		logic [7:0] n;
		pix_bytes = 0;
		while (pix_bytes < RANDOM_PIXEL_BYTES) begin
			f = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0: w = 16'd1;
				1: w = 16'hFFFF;
				2: w = 16'd0;
				default: w = 16'($urandom_range(2, 40));
			endcase
			h = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 40));
			configure(f, w, h);
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(1, 300);
				for (int i = 0; i < k; i++)
					send_byte(8'($urandom_range(0, 255)), i == 0);
			end
			load_palette();
			img_bytes = 0;
			while (!(img_done || row_cnt >= height_reg) && img_bytes < IMAGE_BYTE_BUDGET) begin
				if ($urandom_range(0, 63) == 0)
					in_burst = !in_burst;
				if ($urandom_range(0, 63) == 0)
					out_burst = !out_burst;
				if ($urandom_range(0, 99) == 0) begin
					wait_drained();
					write_reg(CFG_PIXEL_FORMAT, {15'b0, ~fmt_reg}, 1'b0);
				end
				// indices, RGB565 bytes and noise are any byte; else a control
				if (fmt_reg == FMT_RGB565 || lits_left != 0 || $urandom_range(0, 9) == 0) begin
					b = 8'($urandom_range(0, 255));
				end else begin
					case ($urandom_range(0, 9))
						0: n = 8'd0;
						1: n = 8'($urandom_range(64, 127));
						default: n = 8'($urandom_range(1, 12));
					endcase
					b = ($urandom_range(0, 1) != 0) ? (RUN_BLACK_BIT | n) : n;
				end
				send_byte(b, 1'b0);
				img_bytes++;
				pix_bytes++;
			end
			repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);
			in_burst  = 1'b0;
			out_burst = 1'b0;
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		body_byte   = 8'h00;
		image_start = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_PIXEL_FORMAT;
		cfg_data    = 16'h0000;
		in_burst    = 1'b0;
		out_burst   = 1'b0;
		sink_hold   = 0;
		errors      = 0;
		// state after reset: RLE, 1x1, counters clear
		pal_fill    = 0;
		lits_left   = '0;
		col_cnt     = '0;
		row_cnt     = '0;
		low_byte    = '0;
		have_low    = 1'b0;
		img_done    = 1'b0;
		fmt_reg     = FMT_PALETTE_RLE;
		width_reg   = 16'd1;
		height_reg  = 16'd1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_rle_runs();
		test_rgb565();
		test_mode_switch();
		test_zero_sizes();
		test_long_row_stall();
		test_random_images();

		wait_drained();
		if (pending_runs.size() != 0) begin
			$error("%0d expected runs never arrived", pending_runs.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#12_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/prmd_pkg.sv
rtl/core/prmd_palette_ram.sv
rtl/core/prmd_ctrl.sv
rtl/core/palette_rle_mask_decoder.sv
test/palette_rle_mask_decoder_tb.sv
